// ===== rtl/rdt_pkg.sv =====
// Shared types and constants for the rotation direction tachometer.
`timescale 1ns / 1ps

package rdt_pkg;

   // Configuration register map
   localparam int ADDR_W     = 3;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 1'b1;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

   // rpm = (RPM_NUMERATOR / average period) / 2
   localparam logic [15:0] RPM_NUMERATOR = 16'd60000;
   localparam logic [14:0] RPM_MAX       = 15'd30000;

   // Depth of the queue between the front and back ends
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      DIR_STOPPED = 2'd0,
      DIR_CW      = 2'd1,
      DIR_CCW     = 2'd2
   } dir_type;

   typedef struct packed {
      logic tick;
      logic edge_a;
      logic edge_b;
      logic rpm_query;
   } req_type;

   typedef struct packed {
      logic [1:0]  direction;
      logic [14:0] rpm;
      logic        rpm_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] stop_timeout_ms;
   } cfg_type;

   // Word handed from the front end to the back end
   typedef struct packed {
      dir_type     dir;
      logic        query;
      logic        timeout;
      logic [15:0] period;
   } word_type;

endpackage

// ===== rtl/rdt_front.sv =====
// Front end: millisecond clock, debounce, direction sequencing and stop detection.
`timescale 1ns / 1ps

module rdt_front (
   input  logic               clock,
   input  logic               reset,
   input  rdt_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  rdt_pkg::req_type   req_payload,
   output logic               push,
   output rdt_pkg::word_type  push_word,
   input  logic               full
);

   typedef enum logic [1:0] {
      SEQ_IDLE  = 2'd0,
      SEQ_SAW_A = 2'd1,
      SEQ_SAW_B = 2'd2
   } seq_type;

   seq_type           seq_ff, seq_in;
   rdt_pkg::dir_type  dir_ff, dir_in;
   logic [31:0]       ms_ff, stamp_a_ff, stamp_b_ff, last_ff;
   logic [31:0]       ms_in, stamp_a_in, stamp_b_in, last_in;
   logic [15:0]       period_ff, period_in;

   logic [31:0] delta;
   logic        a_ok, b_ok, pulse_done, timeout;

   assign req_ready = !full;
   assign push      = req_valid && req_ready;

   always_comb begin
      ms_in      = ms_ff + 32'(req_payload.tick);
      a_ok       = req_payload.edge_a && ((ms_in - stamp_a_ff) > {16'd0, cfg.debounce_ms});
      b_ok       = req_payload.edge_b && ((ms_in - stamp_b_ff) > {16'd0, cfg.debounce_ms});
      stamp_a_in = a_ok ? ms_in : stamp_a_ff;
      stamp_b_in = b_ok ? ms_in : stamp_b_ff;
      seq_in     = seq_ff;
      dir_in     = dir_ff;
      pulse_done = 1'b0;
      if (a_ok && b_ok) begin
         seq_in = SEQ_IDLE;
      end else if (a_ok) begin
         case (seq_ff)
            SEQ_SAW_B: begin
               dir_in     = rdt_pkg::DIR_CW;
               pulse_done = 1'b1;
               seq_in     = SEQ_IDLE;
            end
            SEQ_IDLE: seq_in = SEQ_SAW_A;
            default:  seq_in = SEQ_IDLE;
         endcase
      end else if (b_ok) begin
         case (seq_ff)
            SEQ_SAW_A: begin
               dir_in     = rdt_pkg::DIR_CCW;
               pulse_done = 1'b1;
               seq_in     = SEQ_IDLE;
            end
            SEQ_IDLE: seq_in = SEQ_SAW_B;
            default:  seq_in = SEQ_IDLE;
         endcase
      end

      // Time since the last completed pulse, counted to this step's millisecond value
      delta     = ms_in - last_ff;
      period_in = period_ff;
      if (pulse_done && (delta < {16'd0, cfg.stop_timeout_ms})) begin
         period_in = delta[15:0];
      end
      last_in = pulse_done ? ms_in : last_ff;

      timeout = req_payload.rpm_query && !pulse_done &&
                (delta > {16'd0, cfg.stop_timeout_ms});
      if (timeout) begin
         seq_in = SEQ_IDLE;
         dir_in = rdt_pkg::DIR_STOPPED;
      end

      push_word.dir     = dir_in;
      push_word.query   = req_payload.rpm_query;
      push_word.timeout = timeout;
      push_word.period  = period_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= SEQ_IDLE;
         dir_ff     <= rdt_pkg::DIR_STOPPED;
         ms_ff      <= '0;
         stamp_a_ff <= '0;
         stamp_b_ff <= '0;
         last_ff    <= '0;
         period_ff  <= '0;
      end else if (push) begin
         seq_ff     <= seq_in;
         dir_ff     <= dir_in;
         ms_ff      <= ms_in;
         stamp_a_ff <= stamp_a_in;
         stamp_b_ff <= stamp_b_in;
         last_ff    <= last_in;
         period_ff  <= period_in;
      end
   end

endmodule

// ===== rtl/rdt_fifo.sv =====
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module rdt_fifo #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rdt_pkg::word_type  push_word,
   output logic               full,
   input  logic               pop,
   output rdt_pkg::word_type  pop_word,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rdt_pkg::word_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_word = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/rdt_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rdt_div #(
   parameter int W = 18
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in, quo_ff, dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [W:0]       rem_shift;
   logic             ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[W-1]};
      ge        = (rem_shift >= {1'b0, dsr_ff});
      rem_in    = ge ? W'(rem_shift - {1'b0, dsr_ff}) : rem_shift[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[W-2:0], ge};
      end
   end

endmodule

// ===== rtl/rdt_back.sv =====
// Back end: period averaging ring, rpm division and the result register.
`timescale 1ns / 1ps

module rdt_back #(
   parameter int AVG_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  rdt_pkg::word_type  word,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rdt_pkg::rsp_type   rsp_payload
);

   localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W     = 16 + $clog2(AVG_DEPTH);
   // average = (sum * REC_MUL) >> REC_SHIFT, exact for every sum the ring can hold
   localparam int REC_SHIFT = SUM_W + 4;
   localparam int REC_W     = REC_SHIFT + 1;
   localparam int PROD_W    = SUM_W + REC_W;
   localparam int REC_MUL   = ((1 << REC_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_AVG  = 2'd1,
      S_RPM  = 2'd2,
      S_OUT  = 2'd3
   } state_type;

   state_type        state_ff;
   logic [15:0]      hist_ff [AVG_DEPTH];
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic             rsp_valid_ff;
   rdt_pkg::rsp_type rsp_ff, pend_ff;

   logic              upd, clr, load;
   logic [PROD_W-1:0] avg_prod;
   logic [15:0]       avg;
   logic              div_start, div_done;
   logic [15:0]       div_dividend, div_divisor, div_quo;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      pop    = (state_ff == S_IDLE) && !empty;
      upd    = pop && word.query && !word.timeout;
      clr    = pop && word.query && word.timeout;
      load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
      sum_in = sum_ff - SUM_W'(hist_ff[idx_ff]) + SUM_W'(word.period);
      idx_in = (idx_ff == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_ff + 1'b1;

      avg_prod = PROD_W'(sum_ff) * PROD_W'(REC_MUL);
      avg      = avg_prod[REC_SHIFT +: 16];

      div_start    = (state_ff == S_AVG) && (avg != '0);
      div_dividend = rdt_pkg::RPM_NUMERATOR;
      div_divisor  = avg;
   end

   rdt_div #(
      .W (16)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Averaging ring with running sum
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         idx_ff <= '0;
         sum_ff <= '0;
      end else if (upd) begin
         hist_ff[idx_ff] <= word.period;
         idx_ff          <= idx_in;
         sum_ff          <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  pend_ff.direction <= word.dir;
                  pend_ff.rpm       <= '0;
                  pend_ff.rpm_valid <= word.query;
                  state_ff          <= upd ? S_AVG : S_OUT;
               end
            end
            S_AVG: begin
               state_ff <= (avg == '0) ? S_OUT : S_RPM;
            end
            S_RPM: begin
               if (div_done) begin
                  pend_ff.rpm <= div_quo[15:1];
                  state_ff    <= S_OUT;
               end
            end
            S_OUT: begin
               if (load) begin
                  rsp_ff   <= pend_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/rotation_direction_tachometer.sv =====
// Top level of the two-sensor rotation direction and rpm tachometer.
`timescale 1ns / 1ps

// Usage
//   req channel: one word per step (tick, edge_a, edge_b, rpm_query), taken
//   when req_valid and req_ready are both high. rsp channel: one word per
//   request word (direction, rpm, rpm_valid), in request order.
//   Configuration: APB-style writes to debounce_ms (address 0) and
//   stop_timeout_ms (address 4); write only while no request is in flight.
// Structure
//   The front end updates the millisecond clock, debounce stamps, direction
//   sequence and stop detection in the cycle a word is taken, then queues a
//   word for the back end. The back end keeps the averaging ring, forms the
//   average by reciprocal multiplication and halves 60000 divided by it.
// Sequencing
//   A step without a query goes from S_IDLE straight to S_OUT and the result
//   register. A query with a nonzero average passes through S_AVG, S_RPM
//   (the one-bit-per-cycle divider) and S_OUT. The back end takes the next
//   word from the queue only after the previous result is loaded.
// Reset and stalls
//   Reset restores both registers to defaults and clears all control state.
//   When rsp_ready is low the result register holds, the queue fills and
//   req_ready drops once the queue is full.

module rotation_direction_tachometer #(
   parameter int AVG_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rdt_pkg::req_type            req_payload,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rdt_pkg::rsp_type            rsp_payload,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rdt_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   rdt_pkg::cfg_type  cfg_ff;
   logic [rdt_pkg::REG_IDX_W-1:0] reg_idx;
   logic              cfg_write;

   rdt_pkg::word_type push_word, pop_word;
   logic              push, pop, full, empty;

   // Register file: one index bit, low address bits ignored
   assign pready    = 1'b1;
   assign reg_idx   = paddr[2];
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      case (reg_idx)
         rdt_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_ff.debounce_ms};
         rdt_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg_ff.stop_timeout_ms};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= rdt_pkg::DEBOUNCE_RESET;
         cfg_ff.stop_timeout_ms <= rdt_pkg::TIMEOUT_RESET;
      end else if (cfg_write) begin
         case (reg_idx)
            rdt_pkg::REG_DEBOUNCE: cfg_ff.debounce_ms     <= pwdata[15:0];
            rdt_pkg::REG_TIMEOUT:  cfg_ff.stop_timeout_ms <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Accept and classify each step
   rdt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_word   (push_word),
      .full        (full)
   );

   // Decouple the two ends
   rdt_fifo #(
      .DEPTH (rdt_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (empty)
   );

   // Average, divide and present results
   rdt_back #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .word        (pop_word),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/rdt_checker.sv =====
// Port-level checks for the tachometer, bound to the top level.
`timescale 1ns / 1ps

module rdt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input rdt_pkg::rsp_type            rsp_payload,
   input logic [31:0]                 prdata
);

   a_rpm_zero_unless_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.rpm_valid) |-> (rsp_payload.rpm == '0))
      else $error("rpm nonzero on a step without query");

   a_rpm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.rpm <= rdt_pkg::RPM_MAX))
      else $error("rpm above range");

   a_direction_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.direction == rdt_pkg::DIR_STOPPED ||
                     rsp_payload.direction == rdt_pkg::DIR_CW ||
                     rsp_payload.direction == rdt_pkg::DIR_CCW))
      else $error("invalid direction code");

   a_prdata_width: assert property (@(posedge clock) disable iff (reset)
      prdata[31:16] == 16'd0)
      else $error("register read wider than 16 bits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind rotation_direction_tachometer rdt_checker u_rdt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .prdata      (prdata)
);
